/* hdl/cdn_pkg.sv */
`default_nettype none
package cdn_pkg;

  // Day offset of the date space: days from 0000-03-01 (shifted by one era)
  // to 1970-01-01.
  localparam logic [22:0] EPOCH_BIAS     = 23'd865565;
  localparam logic [21:0] MAX_DAY_NUMBER = 22'h3FFFFF;
  // floor(x / 25) = (x * RECIP_25) >> RECIP_SHIFT for x < 4196
  localparam logic [12:0] RECIP_25       = 13'd5243;
  localparam int          RECIP_SHIFT    = 17;
  localparam logic [14:0] ERA_YEARS      = 15'd400;
  localparam logic [8:0]  DAYS_PER_YEAR  = 9'd365;
  localparam logic [3:0]  MONTH_FEB      = 4'd2;
  localparam logic [3:0]  MONTH_DEC      = 4'd12;

  // Stage 1 -> stage 2
  typedef struct packed {
    logic [14:0] yy;        // year shifted by one era, March-based
    logic [8:0]  doyp;      // day of March-based year, plus one
    logic [11:0] y4;        // year / 4
    logic        div4;      // year divisible by 4
    logic [4:0]  mlen_nl;   // month length ignoring February
    logic        is_feb;
  } s1_t;

  // Stage 2 -> stage 3
  typedef struct packed {
    logic [22:0] y365;
    logic [12:0] q;         // yy / 4
    logic [24:0] q25p;      // q * RECIP_25
    logic [8:0]  doyp;
    logic [11:0] y4;
    logic [24:0] y25p;      // y4 * RECIP_25
    logic        div4;
    logic [4:0]  mlen_nl;
    logic        is_feb;
  } s2_t;

  // Stage 3 -> stage 4
  typedef struct packed {
    logic [22:0] zp;        // day number plus EPOCH_BIAS
    logic [22:0] zw;        // zp + 3, congruent to weekday mod 7
    logic        leap;
    logic [4:0]  mlen_nl;
    logic        is_feb;
  } s3_t;

  // Cumulative days before month index mp, counted from March.
  function automatic logic [8:0] march_days(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/cdn_decode.sv */
`default_nettype none
module cdn_decode (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic [13:0]     year,
  input  wire logic [3:0]      month,
  input  wire logic [4:0]      day,
  output logic                 s1_valid,
  output cdn_pkg::s1_t         s1
);

  logic [3:0]   m_c;
  logic         early;
  logic [3:0]   mp;
  cdn_pkg::s1_t s1_next;

  always_comb begin
    if (month == 4'd0) begin
      m_c = 4'd1;
    end else if (month > cdn_pkg::MONTH_DEC) begin
      m_c = cdn_pkg::MONTH_DEC;
    end else begin
      m_c = month;
    end
    early = (m_c <= cdn_pkg::MONTH_FEB);
    mp    = early ? m_c + 4'd9 : m_c - 4'd3;

    s1_next.yy      = {1'b0, year} + cdn_pkg::ERA_YEARS - {14'd0, early};
    s1_next.doyp    = cdn_pkg::march_days(mp) + {4'd0, day};
    s1_next.y4      = year[13:2];
    s1_next.div4    = (year[1:0] == 2'd0);
    s1_next.mlen_nl = ({1'b0, m_c} ^ {4'd0, m_c[3]}) | 5'd30;
    s1_next.is_feb  = (m_c == cdn_pkg::MONTH_FEB);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1 <= s1_next;
  end

endmodule
`default_nettype wire

/* hdl/cdn_scale.sv */
`default_nettype none
module cdn_scale (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s1_valid,
  input  wire cdn_pkg::s1_t    s1,
  output logic                 s2_valid,
  output cdn_pkg::s2_t         s2
);

  cdn_pkg::s2_t s2_next;
  logic [23:0]  y365_full;
  logic [25:0]  q25_full;
  logic [24:0]  y25_full;

  // Three independent constant multiplies.
  always_comb begin
    y365_full = {9'd0, s1.yy} * {15'd0, cdn_pkg::DAYS_PER_YEAR};
    q25_full  = {13'd0, s1.yy[14:2]} * {13'd0, cdn_pkg::RECIP_25};
    y25_full  = {13'd0, s1.y4} * {12'd0, cdn_pkg::RECIP_25};

    s2_next.y365    = y365_full[22:0];
    s2_next.q       = s1.yy[14:2];
    s2_next.q25p    = q25_full[24:0];
    s2_next.doyp    = s1.doyp;
    s2_next.y4      = s1.y4;
    s2_next.y25p    = y25_full;
    s2_next.div4    = s1.div4;
    s2_next.mlen_nl = s1.mlen_nl;
    s2_next.is_feb  = s1.is_feb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2 <= s2_next;
  end

endmodule
`default_nettype wire

/* hdl/cdn_accum.sv */
`default_nettype none
module cdn_accum (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s2_valid,
  input  wire cdn_pkg::s2_t    s2,
  output logic                 s3_valid,
  output cdn_pkg::s3_t         s3
);

  logic [7:0]   q25;      // yy / 100
  logic [7:0]   y25;      // year / 100
  logic [11:0]  y25x25;
  logic         c100;
  cdn_pkg::s3_t s3_next;

  always_comb begin
    q25    = s2.q25p[24:cdn_pkg::RECIP_SHIFT];
    y25    = s2.y25p[24:cdn_pkg::RECIP_SHIFT];
    y25x25 = {y25, 4'd0} + {1'b0, y25, 3'd0} + {4'd0, y25};
    c100   = s2.div4 && (s2.y4 == y25x25);

    // 365*yy + yy/4 - yy/100 + yy/400 + doy
    s3_next.zp = s2.y365 + {10'd0, s2.q} - {15'd0, q25} + {17'd0, q25[7:2]}
               + {14'd0, s2.doyp} - 23'd1;
    s3_next.zw      = s3_next.zp + 23'd3;
    s3_next.leap    = s2.div4 && (!c100 || (y25[1:0] == 2'd0));
    s3_next.mlen_nl = s2.mlen_nl;
    s3_next.is_feb  = s2.is_feb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3 <= s3_next;
  end

endmodule
`default_nettype wire

/* hdl/cdn_finish.sv */
`default_nettype none
module cdn_finish (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s3_valid,
  input  wire cdn_pkg::s3_t    s3,
  output logic                 out_valid,
  output logic [21:0]          day_number,
  output logic [2:0]           weekday,
  output logic [4:0]           month_length,
  output logic                 leap_year,
  output logic                 is_weekday
);

  // Stage 4: clamp, first mod-7 fold, month length
  logic        s4_valid;
  logic [21:0] s4_dn;
  logic [5:0]  s4_fold;
  logic [4:0]  s4_mlen;
  logic        s4_leap;

  logic [21:0] dn_next;
  logic [22:0] diff;
  logic [23:0] zw_pad;
  logic [5:0]  fold_next;
  logic [4:0]  mlen_next;

  always_comb begin
    diff = s3.zp - cdn_pkg::EPOCH_BIAS;
    if (s3.zp < cdn_pkg::EPOCH_BIAS) begin
      dn_next = 22'd0;
    end else if (diff[22]) begin
      dn_next = cdn_pkg::MAX_DAY_NUMBER;
    end else begin
      dn_next = diff[21:0];
    end

    // 8 == 1 mod 7: sum of octal digits keeps the residue
    zw_pad    = {1'b0, s3.zw};
    fold_next = 6'd0;
    for (int i = 0; i < 8; i++) begin
      fold_next = fold_next + {3'd0, zw_pad[3*i +: 3]};
    end

    if (s3.is_feb) begin
      mlen_next = s3.leap ? 5'd29 : 5'd28;
    end else begin
      mlen_next = s3.mlen_nl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s4_dn   <= dn_next;
    s4_fold <= fold_next;
    s4_mlen <= mlen_next;
    s4_leap <= s3.leap;
  end

  // Stage 5: finish the residue, output register
  logic [3:0] f2;
  logic [3:0] f3;
  logic [2:0] w_next;

  always_comb begin
    f2 = {1'b0, s4_fold[5:3]} + {1'b0, s4_fold[2:0]};   // <= 14
    f3 = {3'd0, f2[3]} + {1'b0, f2[2:0]};                // <= 8
    w_next = (f3 >= 4'd7) ? 3'(f3 - 4'd7) : f3[2:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    day_number   <= s4_dn;
    weekday      <= w_next;
    month_length <= s4_mlen;
    leap_year    <= s4_leap;
    is_weekday   <= (w_next != 3'd0) && (w_next != 3'd6);
  end

endmodule
`default_nettype wire

/* hdl/civil_date_to_day_number_top.sv */
`default_nettype none
// Gregorian date to day number, fully pipelined.
//
// Input transaction: drive year, month, day and raise start. The date is
// taken at a rising edge where start is high and busy is low. busy is
// always low: a new date can be issued every cycle.
// Result transaction: done is high for one cycle with day_number, weekday,
// month_length, leap_year and is_weekday. The receiver cannot stall; every
// result must be taken in the cycle it appears.
//
// Throughput: one date per cycle. Stages:
//   1  month clamp, March-based year shift, day-of-year table
//   2  constant multiplies (365*yy and two reciprocal divides by 25)
//   3  day-count sum and leap rule
//   4  clamp of day_number to 0..2^22-1, octal fold for mod 7
//   5  final mod 7, output register
// Results leave in issue order. Month 0 acts as January, months above 12
// as December; day is not range checked.
// Reset (rst, synchronous) clears all stage valid bits; items in flight
// are dropped and no done pulse follows from them.
module civil_date_to_day_number_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [13:0] year,
  input  wire logic [3:0]  month,
  input  wire logic [4:0]  day,
  output logic             done,
  output logic [21:0]      day_number,
  output logic [2:0]       weekday,
  output logic [4:0]       month_length,
  output logic             leap_year,
  output logic             is_weekday
);

  logic         s1_valid;
  logic         s2_valid;
  logic         s3_valid;
  cdn_pkg::s1_t s1;
  cdn_pkg::s2_t s2;
  cdn_pkg::s3_t s3;

  // No back-pressure anywhere in the pipe.
  assign busy = 1'b0;

  cdn_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .year     (year),
    .month    (month),
    .day      (day),
    .s1_valid (s1_valid),
    .s1       (s1)
  );

  cdn_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s2_valid (s2_valid),
    .s2       (s2)
  );

  cdn_accum u_accum (
    .clk      (clk),
    .rst      (rst),
    .s2_valid (s2_valid),
    .s2       (s2),
    .s3_valid (s3_valid),
    .s3       (s3)
  );

  cdn_finish u_finish (
    .clk          (clk),
    .rst          (rst),
    .s3_valid     (s3_valid),
    .s3           (s3),
    .out_valid    (done),
    .day_number   (day_number),
    .weekday      (weekday),
    .month_length (month_length),
    .leap_year    (leap_year),
    .is_weekday   (is_weekday)
  );

  // Every result traces back to an accepted transaction.
  a_done_has_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 5))
    else $error("done without matching start");

  // Weekday residue fully reduced.
  a_weekday_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (weekday <= 3'd6))
    else $error("weekday out of range");

  // February's 29th day only in leap years; length always 28..31.
  a_mlen_leap: assert property (@(posedge clk) disable iff (rst)
    done |-> ((month_length != 5'd29 || leap_year) &&
              month_length >= 5'd28 && month_length <= 5'd31))
    else $error("month length inconsistent with leap flag");

  // Workday flag follows the weekday.
  a_workday: assert property (@(posedge clk) disable iff (rst)
    done |-> (is_weekday == (weekday != 3'd0 && weekday != 3'd6)))
    else $error("is_weekday mismatch");

endmodule
`default_nettype wire

/* test/civil_date_to_day_number_top_tb.sv */
`default_nettype none
module civil_date_to_day_number_top_tb;

  // Slowest correct run: ~1680 transactions, sender gaps at most 55% of the time.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Pipeline depth from the accepting edge to the end of the done cycle.
  localparam int unsigned PIPE_DEPTH  = 5;
  localparam int unsigned RANDOM_PER_PHASE = 550;

  typedef struct packed {
    logic [21:0] day_number;
    logic [2:0]  weekday;
    logic [4:0]  month_length;
    logic        leap_year;
    logic        is_weekday;
  } date_result_t;

  // One row of the directed table. When typed is set, res holds the
  // expected result written by hand; otherwise the predictor supplies it.
  typedef struct packed {
    logic [13:0]  y;
    logic [3:0]   m;
    logic [4:0]   d;
    logic         typed;
    date_result_t res;
  } date_case_t;

  localparam int unsigned NUM_DIRECTED = 22;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [13:0] year = '0;
  logic [3:0]  month = '0;
  logic [4:0]  day = '0;
  logic busy;
  logic done;
  logic [21:0] day_number;
  logic [2:0]  weekday;
  logic [4:0]  month_length;
  logic        leap_year;
  logic        is_weekday;

  // Hand-typed expectation travels with the date so the monitor picks it up
  // at the same edge that accepts the transaction.
  logic         use_typed = 1'b0;
  date_result_t typed_res = '0;

  date_result_t pending_conversions [$];
  date_result_t oldest;
  int unsigned  errors = 0;
  int unsigned  cycle_count = 0;

  date_case_t directed_cases [NUM_DIRECTED] = '{
    // epoch itself: Thursday
    '{14'd1970, 4'd1,  5'd1,  1'b1, '{22'd0,       3'd4, 5'd31, 1'b0, 1'b1}},
    // the day before the epoch clamps to zero, still a Wednesday
    '{14'd1969, 4'd12, 5'd31, 1'b1, '{22'd0,       3'd3, 5'd31, 1'b0, 1'b1}},
    // day zero of the epoch month, same date as above
    '{14'd1970, 4'd1,  5'd0,  1'b1, '{22'd0,       3'd3, 5'd31, 1'b0, 1'b1}},
    // month zero behaves as January
    '{14'd1970, 4'd0,  5'd1,  1'b1, '{22'd0,       3'd4, 5'd31, 1'b0, 1'b1}},
    // leap day of a 400-year century
    '{14'd2000, 4'd2,  5'd29, 1'b1, '{22'd11016,   3'd2, 5'd29, 1'b1, 1'b1}},
    // last date of the intended range, a Friday
    '{14'd9999, 4'd12, 5'd31, 1'b1, '{22'd2932896, 3'd5, 5'd31, 1'b0, 1'b1}},
    // every other row goes through the predictor
    '{14'd0,     4'd0,  5'd0,  1'b0, '0},   // year zero, all-zero fields
    '{14'd16383, 4'd15, 5'd31, 1'b0, '0},   // all ones, saturated count
    '{14'd16383, 4'd1,  5'd1,  1'b0, '0},
    '{14'd1900,  4'd2,  5'd28, 1'b0, '0},   // plain century, not leap
    '{14'd2100,  4'd2,  5'd29, 1'b0, '0},   // spills into March
    '{14'd2400,  4'd2,  5'd29, 1'b0, '0},
    '{14'd2024,  4'd2,  5'd30, 1'b0, '0},
    '{14'd2023,  4'd3,  5'd0,  1'b0, '0},   // day zero of March
    '{14'd2023,  4'd4,  5'd31, 1'b0, '0},   // past the end of a 30-day month
    '{14'd2023,  4'd6,  5'd15, 1'b0, '0},
    '{14'd2023,  4'd9,  5'd30, 1'b0, '0},
    '{14'd2023,  4'd11, 5'd1,  1'b0, '0},
    '{14'd2023,  4'd13, 5'd10, 1'b0, '0},   // months above twelve act as December
    '{14'd2023,  4'd14, 5'd31, 1'b0, '0},
    '{14'd13453, 4'd8,  5'd12, 1'b0, '0},   // exactly the top of the 22-bit count
    '{14'd13000, 4'd8,  5'd8,  1'b0, '0}
  };

  civil_date_to_day_number_top uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .year         (year),
    .month        (month),
    .day          (day),
    .done         (done),
    .day_number   (day_number),
    .weekday      (weekday),
    .month_length (month_length),
    .leap_year    (leap_year),
    .is_weekday   (is_weekday)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor: era / year-of-era / March-based day of year, then clamp.
  function automatic date_result_t convert_date(input logic [13:0] y_in,
                                                input logic [3:0]  m_in,
                                                input logic [4:0]  d_in);
    longint yr;
    longint mo;
    longint dy;
    longint shifted;
    longint era;
    longint yoe;
    longint mp;
    longint doy;
    longint doe;
    longint days;
    longint wd;
    bit leap;
    date_result_t r;
    yr = longint'(y_in);
    mo = longint'(m_in);
    dy = longint'(d_in);
    if (mo < 1) mo = 1;
    else if (mo > 12) mo = 12;
    leap = (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
    // shift one era up so the March-based year never goes negative
    shifted = yr + 400 - ((mo <= 2) ? 1 : 0);
    era = shifted / 400;
    yoe = shifted % 400;
    mp = (mo > 2) ? mo - 3 : mo + 9;
    doy = (153 * mp + 2) / 5 + dy - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    days = (era - 1) * 146097 + doe - 719468;
    // truncating remainder, then rebase: the epoch fell on a Thursday
    wd = ((days % 7) + 11) % 7;
    if (days < 0)
      r.day_number = '0;
    else if (days > longint'(cdn_pkg::MAX_DAY_NUMBER))
      r.day_number = cdn_pkg::MAX_DAY_NUMBER;
    else
      r.day_number = days[21:0];
    r.weekday = wd[2:0];
    if (mo == 2)
      r.month_length = leap ? 5'd29 : 5'd28;
    else if (mo == 4 || mo == 6 || mo == 9 || mo == 11)
      r.month_length = 5'd30;
    else
      r.month_length = 5'd31;
    r.leap_year = leap;
    r.is_weekday = (wd >= 1 && wd <= 5);
    return r;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Scoreboard: check a done pulse against the oldest pending transaction,
  // then record the transaction accepted at this edge. Both sides sample
  // pre-edge values, so ordering within the time step does not matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (pending_conversions.size() == 0) begin
          $error("done pulse with no pending date");
          errors++;
        end else begin
          oldest = pending_conversions.pop_front();
          compare_field("day_number", 32'(oldest.day_number), 32'(day_number));
          compare_field("weekday", 32'(oldest.weekday), 32'(weekday));
          compare_field("month_length", 32'(oldest.month_length),
                        32'(month_length));
          compare_field("leap_year", 32'(oldest.leap_year), 32'(leap_year));
          compare_field("is_weekday", 32'(oldest.is_weekday), 32'(is_weekday));
        end
      end
      if (start && !busy)
        pending_conversions.push_back(use_typed ? typed_res
                                                : convert_date(year, month, day));
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Present one date and hold it until the transaction is taken. Returns at
  // the accepting edge; the caller either drives the next date or idles.
  task automatic send_date(input logic [13:0] y, input logic [3:0] m,
                           input logic [4:0] d, input logic typed,
                           input date_result_t res);
    year <= y;
    month <= m;
    day <= d;
    use_typed <= typed;
    typed_res <= res;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Random sender gap, so bubbles land on every stage.
  task automatic maybe_idle(input int unsigned idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  // Mostly well-formed dates in the intended range; the rest lean on
  // special years with any month and day, or are raw random bits.
  task automatic pick_random_date(output logic [13:0] y, output logic [3:0] m,
                                  output logic [4:0] d);
    int unsigned sel;
    int unsigned special_years [9] = '{0, 1969, 1970, 1971, 2000, 2100, 2400,
                                       9999, 16383};
    date_result_t probe;
    sel = $urandom_range(99);
    if (sel < 70) begin
      y = 14'($urandom_range(9999, 1970));
      m = 4'($urandom_range(12, 1));
      probe = convert_date(y, m, 5'd1);
      d = 5'($urandom_range(32'(probe.month_length), 1));
    end else if (sel < 82) begin
      y = 14'(special_years[$urandom_range(8)]);
      m = 4'($urandom_range(15));
      d = 5'($urandom_range(31));
    end else begin
      y = 14'($urandom());
      m = 4'($urandom());
      d = 5'($urandom());
    end
  endtask

  initial begin
    logic [13:0] ry;
    logic [3:0]  rm;
    logic [4:0]  rd;
    int unsigned idle_pct;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, sender idling 31% of the time
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_date(directed_cases[i].y, directed_cases[i].m, directed_cases[i].d,
                directed_cases[i].typed, directed_cases[i].res);
      maybe_idle(31);
    end

    // random phases: sender idles 31%, then 55%, then back to back
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 31 : (phase == 1) ? 55 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        pick_random_date(ry, rm, rd);
        send_date(ry, rm, rd, 1'b0, '0);
        maybe_idle(idle_pct);
      end
    end
    start <= 1'b0;

    // drain the pipeline, then watch a little longer for stray done pulses
    while (pending_conversions.size() != 0) @(posedge clk);
    repeat (2 * PIPE_DEPTH) @(posedge clk);

    if (pending_conversions.size() != 0) begin
      $error("%0d dates never completed", pending_conversions.size());
      errors++;
    end

    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire
